// File: rtl/core/pcd_pkg.sv
// Package with character codes, result beat type and decode helpers for the percent decoder.
package pcd_pkg;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam int unsigned CountW    = 16;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [2:0] REG_OUT_LIMIT_IDX = 3'd0;

  // One result beat as it waits in the output queue.
  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              run_done;
    logic [CountW-1:0] out_count;
  } out_beat_t;

  // Hex digit value; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  // Value of a two-character escape, following base-16 text-to-number rules.
  function automatic logic [7:0] parse_pair(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] ha;
    logic [4:0] hb;
    logic [7:0] r;
    ha = hex_digit(a);
    hb = hex_digit(b);
    r  = 8'd0;
    if (is_blank(a) || a == CHAR_PLUS) begin
      r = hb[4] ? {4'd0, hb[3:0]} : 8'd0;
    end else if (a == CHAR_MINUS) begin
      r = hb[4] ? (8'd0 - {4'd0, hb[3:0]}) : 8'd0;
    end else if (ha[4]) begin
      r = hb[4] ? {ha[3:0], hb[3:0]} : {4'd0, ha[3:0]};
    end
    return r;
  endfunction

  function automatic logic [7:0] plain_char(input logic [7:0] c);
    return (c == CHAR_PLUS) ? CHAR_SPACE : c;
  endfunction

endpackage

// File: rtl/core/percent_decoder.sv
// Top level of the streaming URL percent decoder.
//
// Input stream: one encoded character per beat on s_axis_tdata, s_axis_tlast on the
// final character of a string. Output stream: one result per beat; m_axis_tdata holds
// the decoded byte and the running count, m_axis_tuser says whether the byte is real,
// m_axis_tlast marks the final result of the string. A string gives one result per
// emitted byte, and its final character always gives at least one result (a beat with
// tuser low when nothing was emitted on it). '%' followed by only one more character
// can yield two results from that character's input beat.
// Each result passes through the input register, then the four-entry result queue.
// Throughput: one input beat per cycle, set by the combinational decode between the
// input register and the queue; s_axis_tready drops only while the queue holds more
// than two results.
// The APB port holds out_limit at address 0; write it only while the block is idle.
// Reset clears the decode state, empties the queue and sets out_limit to 65535.
// When the receiver stalls, results collect in the queue and the input then stalls.
module percent_decoder
  import pcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] out_count
  output logic        m_axis_tuser,   // byte_valid
  output logic        m_axis_tlast,   // run_done
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } phase_e;

  // Configuration register
  logic [CountW-1:0] out_limit_q;
  logic              cfg_wr;
  logic              cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == REG_OUT_LIMIT_IDX[0]);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? {16'd0, out_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_limit_q <= '1;
    end else if (cfg_wr) begin
      out_limit_q <= pwdata[CountW-1:0];
    end
  end

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       fire;

  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Result queue state
  out_beat_t            queue_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueuePtrW:0]   fill_q;
  logic                 pop;

  assign fire = in_valid_q && (fill_q <= (QueuePtrW+1)'(QueueDepth - 2));

  // Decode state
  phase_e            phase_q, phase_d;
  logic [7:0]        first_q, first_d;
  logic [CountW-1:0] emitted_q, emitted_d;
  logic              cap_q, cap_d;

  logic       want0, want1, ok0, ok1, dummy;
  logic [7:0] byte0, byte1;
  logic [CountW:0] cnt_p1, cnt_p2;
  out_beat_t  beat0, beat1;
  logic [1:0] n_push;

  // Single-pass decode of the registered character.
  always_comb begin
    phase_d = phase_q;
    first_d = first_q;
    want0   = 1'b0;
    want1   = 1'b0;
    byte0   = 8'd0;
    byte1   = plain_char(in_byte_q);
    case (phase_q)
      PH_PCT: begin
        if (in_last_q) begin
          want0   = 1'b1;
          byte0   = CHAR_PCT;
          want1   = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          first_d = in_byte_q;
          phase_d = PH_DIG;
        end
      end
      PH_DIG: begin
        want0   = 1'b1;
        byte0   = parse_pair(first_q, in_byte_q);
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
        if (in_byte_q == CHAR_PCT) begin
          if (in_last_q) begin
            want0 = 1'b1;
            byte0 = CHAR_PCT;
          end else begin
            phase_d = PH_PCT;
          end
        end else begin
          want0 = 1'b1;
          byte0 = plain_char(in_byte_q);
        end
      end
    endcase

    // Each emission is checked against the limit; a refusal latches.
    cnt_p1 = {1'b0, emitted_q} + 17'd1;
    cnt_p2 = {1'b0, emitted_q} + 17'd2;
    ok0    = want0 && !cap_q && (cnt_p1 < {1'b0, out_limit_q});
    ok1    = want1 && ok0 && (cnt_p2 < {1'b0, out_limit_q});
    dummy  = in_last_q && !ok0;
    cap_d  = cap_q || (want0 && !ok0) || (want1 && !ok1);
    emitted_d = emitted_q + CountW'(ok0) + CountW'(ok1);

    if (in_last_q) begin
      phase_d   = PH_IDLE;
      emitted_d = '0;
      cap_d     = 1'b0;
    end

    beat0.out_byte   = ok0 ? byte0 : 8'd0;
    beat0.byte_valid = ok0;
    beat0.run_done   = in_last_q && !ok1;
    beat0.out_count  = ok0 ? cnt_p1[CountW-1:0] : emitted_q;
    beat1.out_byte   = byte1;
    beat1.byte_valid = 1'b1;
    beat1.run_done   = in_last_q;
    beat1.out_count  = cnt_p2[CountW-1:0];

    n_push = {1'b0, ok0 || dummy} + {1'b0, ok1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      first_q   <= 8'd0;
      emitted_q <= '0;
      cap_q     <= 1'b0;
    end else if (fire) begin
      phase_q   <= phase_d;
      first_q   <= first_d;
      emitted_q <= emitted_d;
      cap_q     <= cap_d;
    end
  end

  // Result queue: up to two writes and one read per cycle.
  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (fire && n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= beat0;
    end
    if (fire && ok1) begin
      queue_q[wr_ptr_q + QueuePtrW'(1)] <= beat1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (fire) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(n_push);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      fill_q <= fill_q + (fire ? (QueuePtrW+1)'(n_push) : '0) - (QueuePtrW+1)'(pop);
    end
  end

  assign m_axis_tvalid = (fill_q != '0);
  assign m_axis_tdata  = {queue_q[rd_ptr_q].out_count, queue_q[rd_ptr_q].out_byte};
  assign m_axis_tuser  = queue_q[rd_ptr_q].byte_valid;
  assign m_axis_tlast  = queue_q[rd_ptr_q].run_done;

  // The queue never holds more entries than it has.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (QueuePtrW+1)'(QueueDepth))
    else $error("result queue overflow");

  // A decode step only runs when the queue has room for two results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> fill_q <= (QueuePtrW+1)'(QueueDepth - 2))
    else $error("decode step without queue room");

  // A result without a byte only closes a string and carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[7:0] == 8'd0))
    else $error("empty result not at end of string");

endmodule
